@@ design/fqs_pkg.sv @@
package fqs_pkg;

    localparam int DEPTH_DEFAULT      = 16;
    localparam int DATA_WIDTH_DEFAULT = 32;

    localparam int CMD_W   = 3;
    localparam int INDEX_W = 4;

    localparam logic [CMD_W-1:0] CMD_PUSH = 3'd0;
    localparam logic [CMD_W-1:0] CMD_POP  = 3'd1;
    localparam logic [CMD_W-1:0] CMD_DROP = 3'd2;
    localparam logic [CMD_W-1:0] CMD_FIND = 3'd3;
    localparam logic [CMD_W-1:0] CMD_SIZE = 3'd4;
    localparam logic [CMD_W-1:0] CMD_READ = 3'd5;

    // per-cycle orders broadcast along the cell row
    typedef struct packed {
        logic load;
        logic shift;
        logic rotate;
    } cell_ctl_t;

endpackage

@@ design/fqs_cell.sv @@
module fqs_cell #(
    parameter int DATA_WIDTH = fqs_pkg::DATA_WIDTH_DEFAULT,
    parameter int DEPTH      = fqs_pkg::DEPTH_DEFAULT,
    parameter int CELL_IDX   = 0
) (
    input  logic                                clk,
    input  fqs_pkg::cell_ctl_t                  ctl,
    input  logic [$clog2(DEPTH+1)-1:0]          count,
    input  logic signed [DATA_WIDTH-1:0]        push_value,
    input  logic signed [DATA_WIDTH-1:0]        head_value,
    input  logic signed [DATA_WIDTH-1:0]        right_value,
    output logic signed [DATA_WIDTH-1:0]        data
);

    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [CNT_W-1:0] POS_NEXT = CNT_W'(CELL_IDX + 1);
    localparam logic [CNT_W-1:0] POS_SELF = CNT_W'(CELL_IDX);

    logic signed [DATA_WIDTH-1:0] data_reg;
    logic signed [DATA_WIDTH-1:0] data_next;

    always_comb
    begin
        data_next = data_reg;
        if (ctl.load && (count == POS_SELF))
        begin
            data_next = push_value;
        end
        else if (ctl.shift)
        begin
            data_next = right_value;
        end
        else if (ctl.rotate)
        begin
            // last occupied cell closes the ring back to the head
            if (count == POS_NEXT)
            begin
                data_next = head_value;
            end
            else if (count > POS_NEXT)
            begin
                data_next = right_value;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data = data_reg;

endmodule

@@ design/fqs_ctrl.sv @@
module fqs_ctrl #(
    parameter int DATA_WIDTH = fqs_pkg::DATA_WIDTH_DEFAULT,
    parameter int DEPTH      = fqs_pkg::DEPTH_DEFAULT
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    input  logic [fqs_pkg::CMD_W-1:0]           command,
    input  logic signed [DATA_WIDTH-1:0]        value_in,
    input  logic [fqs_pkg::INDEX_W-1:0]         index_in,
    input  logic signed [DATA_WIDTH-1:0]        head_value,
    output fqs_pkg::cell_ctl_t                  ctl,
    output logic [$clog2(DEPTH+1)-1:0]          count,
    output logic                                busy,
    output logic                                done,
    output logic                                ok,
    output logic signed [DATA_WIDTH-1:0]        value_out,
    output logic [$clog2(DEPTH+1)-1:0]          position
);

    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int IDX_W = $clog2(DEPTH);
    localparam int CMP_W = (CNT_W > fqs_pkg::INDEX_W) ? CNT_W : fqs_pkg::INDEX_W;

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_WALK = 1'b1;

    logic                         state_reg, state_next;
    logic [CNT_W-1:0]             count_reg, count_next;
    logic [IDX_W-1:0]             step_reg, step_next;
    logic                         done_reg, done_next;
    logic                         ok_reg, ok_next;
    logic signed [DATA_WIDTH-1:0] value_out_reg, value_out_next;
    logic [CNT_W-1:0]             position_reg, position_next;
    logic signed [DATA_WIDTH-1:0] key_reg, key_next;
    logic [IDX_W-1:0]             idx_reg, idx_next;
    logic                         is_find_reg, is_find_next;

    logic [CMP_W-1:0] idx_ext;
    logic [CMP_W-1:0] last_ext;
    logic [CNT_W-1:0] step_plus;

    assign idx_ext   = CMP_W'(index_in);
    assign last_ext  = CMP_W'(count_reg) - CMP_W'(1);
    assign step_plus = CNT_W'(step_reg) + CNT_W'(1);

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        step_next      = step_reg;
        done_next      = 1'b0;
        ok_next        = ok_reg;
        value_out_next = value_out_reg;
        position_next  = position_reg;
        key_next       = key_reg;
        idx_next       = idx_reg;
        is_find_next   = is_find_reg;
        ctl            = '0;

        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    ok_next        = 1'b0;
                    value_out_next = '0;
                    position_next  = '0;
                    done_next      = 1'b1;
                    case (command)
                        fqs_pkg::CMD_PUSH:
                        begin
                            if (count_reg < CNT_W'(DEPTH))
                            begin
                                ctl.load   = 1'b1;
                                count_next = count_reg + CNT_W'(1);
                                ok_next    = 1'b1;
                            end
                        end
                        fqs_pkg::CMD_POP:
                        begin
                            if (count_reg != '0)
                            begin
                                ctl.shift      = 1'b1;
                                value_out_next = head_value;
                                count_next     = count_reg - CNT_W'(1);
                                ok_next        = 1'b1;
                            end
                        end
                        fqs_pkg::CMD_DROP:
                        begin
                            if (count_reg != '0)
                            begin
                                count_next = count_reg - CNT_W'(1);
                                ok_next    = 1'b1;
                            end
                        end
                        fqs_pkg::CMD_FIND, fqs_pkg::CMD_READ:
                        begin
                            if (count_reg != '0)
                            begin
                                done_next    = 1'b0;
                                state_next   = ST_WALK;
                                step_next    = '0;
                                key_next     = value_in;
                                is_find_next = (command == fqs_pkg::CMD_FIND);
                                idx_next     = IDX_W'((idx_ext > last_ext) ? last_ext : idx_ext);
                            end
                        end
                        fqs_pkg::CMD_SIZE:
                        begin
                            ok_next = (count_reg != '0);
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_WALK:
            begin
                // one full turn of the occupied ring restores the order
                ctl.rotate = 1'b1;
                if (is_find_reg && !ok_reg && (head_value == key_reg))
                begin
                    ok_next       = 1'b1;
                    position_next = step_plus;
                end
                if (!is_find_reg && (step_reg == idx_reg))
                begin
                    ok_next        = 1'b1;
                    value_out_next = head_value;
                end
                if (step_plus == count_reg)
                begin
                    state_next = ST_IDLE;
                    done_next  = 1'b1;
                end
                else
                begin
                    step_next = step_reg + IDX_W'(1);
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
            step_reg  <= '0;
            done_reg  <= 1'b0;
            ok_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            step_reg  <= step_next;
            done_reg  <= done_next;
            ok_reg    <= ok_next;
        end
    end

    always_ff @(posedge clk)
    begin
        value_out_reg <= value_out_next;
        position_reg  <= position_next;
        key_reg       <= key_next;
        idx_reg       <= idx_next;
        is_find_reg   <= is_find_next;
    end

    assign count     = count_reg;
    assign busy      = (state_reg == ST_WALK);
    assign done      = done_reg;
    assign ok        = ok_reg;
    assign value_out = value_out_reg;
    assign position  = position_reg;

endmodule

@@ design/fifo_queue_with_search_unit.sv @@
// Bounded FIFO of signed words kept in a row of cells in queue order, the
// head in the first cell. A command is taken when start is high and busy is
// low; its single result beat is registered and shown with done high for
// exactly one cycle, and the receiver cannot stall it. Push, pop, drop, size
// and any command that fails on an empty queue show their result in the
// cycle after they are taken, and the next command can be taken in the cycle
// the result is shown. Find and read at index turn the occupied cells once
// around their ring, one position per cycle past the head comparator, with
// busy high while the ring turns.
module fifo_queue_with_search_unit #(
    parameter int DEPTH      = fqs_pkg::DEPTH_DEFAULT,
    parameter int DATA_WIDTH = fqs_pkg::DATA_WIDTH_DEFAULT
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    input  logic [fqs_pkg::CMD_W-1:0]           command,
    input  logic signed [DATA_WIDTH-1:0]        value_in,
    input  logic [fqs_pkg::INDEX_W-1:0]         index_in,
    output logic                                busy,
    output logic                                done,
    output logic                                ok,
    output logic signed [DATA_WIDTH-1:0]        value_out,
    output logic [$clog2(DEPTH+1)-1:0]          position,
    output logic [$clog2(DEPTH+1)-1:0]          entry_count
);

    localparam int CNT_W = $clog2(DEPTH + 1);

    fqs_pkg::cell_ctl_t           ctl;
    logic [CNT_W-1:0]             count;
    logic signed [DATA_WIDTH-1:0] cell_data [DEPTH];

    fqs_ctrl #(
        .DATA_WIDTH (DATA_WIDTH),
        .DEPTH      (DEPTH)
    ) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .command    (command),
        .value_in   (value_in),
        .index_in   (index_in),
        .head_value (cell_data[0]),
        .ctl        (ctl),
        .count      (count),
        .busy       (busy),
        .done       (done),
        .ok         (ok),
        .value_out  (value_out),
        .position   (position)
    );

    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        logic signed [DATA_WIDTH-1:0] right_value;

        if (i == DEPTH - 1)
        begin : g_last
            assign right_value = cell_data[i];
        end
        else
        begin : g_inner
            assign right_value = cell_data[i+1];
        end

        fqs_cell #(
            .DATA_WIDTH (DATA_WIDTH),
            .DEPTH      (DEPTH),
            .CELL_IDX   (i)
        ) u_cell (
            .clk         (clk),
            .ctl         (ctl),
            .count       (count),
            .push_value  (value_in),
            .head_value  (cell_data[0]),
            .right_value (right_value),
            .data        (cell_data[i])
        );
    end

    assign entry_count = count;

endmodule

@@ bench/tb_fifo_queue_with_search_unit.sv @@
module tb_fifo_queue_with_search_unit;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH = fqs_pkg::DEPTH_DEFAULT;
    localparam int DW    = fqs_pkg::DATA_WIDTH_DEFAULT;
    localparam int CW    = $clog2(DEPTH + 1);
    localparam int CMDW  = fqs_pkg::CMD_W;
    localparam int IXW   = fqs_pkg::INDEX_W;

    localparam logic [CMDW-1:0] CMD_SPARE_6 = 3'd6;
    localparam logic [CMDW-1:0] CMD_SPARE_7 = 3'd7;

    localparam int ITEMS_PER_PHASE = 200;

    typedef struct {
        logic                 ok;
        logic signed [DW-1:0] value;
        logic [CW-1:0]        position;
        logic [CW-1:0]        count;
    } queue_reply_t;

    class queue_scoreboard;
        logic signed [DW-1:0] slots [DEPTH];
        int                   head;
        int                   fill;
        queue_reply_t         pending_replies [$];
        int                   mismatches;

        function new();
            head       = 0;
            fill       = 0;
            mismatches = 0;
        endfunction

        function void note_command(logic [CMDW-1:0] cmd, logic signed [DW-1:0] val,
                                   logic [IXW-1:0] idx);
            queue_reply_t r;
            int           k;
            int           pick;
            r.ok       = 1'b0;
            r.value    = '0;
            r.position = '0;
            case (cmd)
                fqs_pkg::CMD_PUSH:
                    if (fill < DEPTH)
                    begin
                        slots[(head + fill) % DEPTH] = val;
                        fill++;
                        r.ok = 1'b1;
                    end
                fqs_pkg::CMD_POP:
                    if (fill > 0)
                    begin
                        r.value = slots[head];
                        head    = (head + 1) % DEPTH;
                        fill--;
                        r.ok    = 1'b1;
                    end
                fqs_pkg::CMD_DROP:
                    if (fill > 0)
                    begin
                        fill--;
                        if (fill == 0)
                            head = 0;
                        r.ok = 1'b1;
                    end
                fqs_pkg::CMD_FIND:
                    for (k = 0; k < fill && !r.ok; k++)
                    begin
                        if (slots[(head + k) % DEPTH] == val)
                        begin
                            r.position = CW'(k + 1);
                            r.ok       = 1'b1;
                        end
                    end
                fqs_pkg::CMD_SIZE:
                    r.ok = (fill > 0);
                fqs_pkg::CMD_READ:
                    if (fill > 0)
                    begin
                        pick    = (int'(idx) > fill - 1) ? fill - 1 : int'(idx);
                        r.value = slots[(head + pick) % DEPTH];
                        r.ok    = 1'b1;
                    end
                default:
                    ;
            endcase
            r.count = CW'(fill);
            pending_replies.push_back(r);
        endfunction

        function void flag(string what);
            mismatches++;
            if (mismatches <= 10)
                $display("mismatch at %0t ns: %s", $time, what);
        endfunction

        function void check_result(logic ok, logic signed [DW-1:0] value,
                                   logic [CW-1:0] position, logic [CW-1:0] count);
            queue_reply_t want;
            if (pending_replies.size() == 0)
            begin
                flag("result beat with no command outstanding");
                return;
            end
            want = pending_replies.pop_front();
            if (ok !== want.ok)
                flag($sformatf("ok: expected %0b, got %0b", want.ok, ok));
            if (value !== want.value)
                flag($sformatf("value_out: expected %0d, got %0d", want.value, value));
            if (position !== want.position)
                flag($sformatf("position: expected %0d, got %0d", want.position, position));
            if (count !== want.count)
                flag($sformatf("entry_count: expected %0d, got %0d", want.count, count));
        endfunction
    endclass

    logic                 clk;
    logic                 rst_n;
    logic                 start;
    logic [CMDW-1:0]      command;
    logic signed [DW-1:0] value_in;
    logic [IXW-1:0]       index_in;
    logic                 busy;
    logic                 done;
    logic                 ok;
    logic signed [DW-1:0] value_out;
    logic [CW-1:0]        position;
    logic [CW-1:0]        entry_count;

    queue_scoreboard sb;
    int              sender_idle_pct;

    fifo_queue_with_search_unit #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DW)
    ) u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .command     (command),
        .value_in    (value_in),
        .index_in    (index_in),
        .busy        (busy),
        .done        (done),
        .ok          (ok),
        .value_out   (value_out),
        .position    (position),
        .entry_count (entry_count)
    );

    initial clk = 1'b0;

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    initial
    begin
        #5ms;
        $display("FAILURE");
        $finish;
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (done)
                sb.check_result(ok, value_out, position, entry_count);
            if (start && !busy)
                sb.note_command(command, value_in, index_in);
        end
    end

    // called at a falling edge, returns at the falling edge after the beat is taken
    task automatic send_command(logic [CMDW-1:0] cmd, logic signed [DW-1:0] val,
                                logic [IXW-1:0] idx);
        int gap;
        gap = 0;
        while (gap < 40 && $urandom_range(99) < sender_idle_pct)
            gap++;
        if (gap > 0)
        begin
            start = 1'b0;
            repeat (gap) @(negedge clk);
        end
        start    = 1'b1;
        command  = cmd;
        value_in = val;
        index_in = idx;
        do
            @(posedge clk);
        while (busy);
        @(negedge clk);
    endtask

    function automatic logic signed [DW-1:0] pick_value();
        case ($urandom_range(9))
            0:       return 32'sh7fff_ffff;
            1:       return 32'sh8000_0000;
            2:       return '0;
            3:       return -1;
            4:       return 32'sd5;
            5:       return 32'sh55aa_55aa;
            default: return $urandom();
        endcase
    endfunction

    function automatic logic [CMDW-1:0] pick_command(bit filling);
        int r;
        r = $urandom_range(99);
        if (filling)
        begin
            if (r < 55) return fqs_pkg::CMD_PUSH;
            if (r < 65) return fqs_pkg::CMD_POP;
            if (r < 70) return fqs_pkg::CMD_DROP;
            if (r < 82) return fqs_pkg::CMD_FIND;
            if (r < 87) return fqs_pkg::CMD_SIZE;
            if (r < 98) return fqs_pkg::CMD_READ;
        end
        else
        begin
            if (r < 20) return fqs_pkg::CMD_PUSH;
            if (r < 50) return fqs_pkg::CMD_POP;
            if (r < 65) return fqs_pkg::CMD_DROP;
            if (r < 80) return fqs_pkg::CMD_FIND;
            if (r < 85) return fqs_pkg::CMD_SIZE;
            if (r < 98) return fqs_pkg::CMD_READ;
        end
        return r[0] ? CMD_SPARE_7 : CMD_SPARE_6;
    endfunction

    initial
    begin
        int  phase;
        int  n;
        int  mode_left;
        bit  filling;
        sb              = new();
        sender_idle_pct = 0;
        rst_n           = 1'b0;
        start           = 1'b0;
        command         = fqs_pkg::CMD_SIZE;
        value_in        = '0;
        index_in        = '0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // empty queue and unused codes
        send_command(fqs_pkg::CMD_SIZE, '0, '0);
        send_command(fqs_pkg::CMD_POP, '0, '0);
        send_command(fqs_pkg::CMD_DROP, '0, '0);
        send_command(fqs_pkg::CMD_READ, '0, 4'd15);
        send_command(fqs_pkg::CMD_FIND, '0, '0);
        send_command(CMD_SPARE_6, -1, 4'd15);
        send_command(CMD_SPARE_7, 32'sh8000_0000, '0);
        // field extremes
        send_command(fqs_pkg::CMD_PUSH, 32'sh7fff_ffff, '0);
        send_command(fqs_pkg::CMD_PUSH, 32'sh8000_0000, 4'd15);
        send_command(fqs_pkg::CMD_PUSH, '0, '0);
        send_command(fqs_pkg::CMD_PUSH, -1, '0);
        send_command(fqs_pkg::CMD_FIND, 32'sh8000_0000, '0);
        send_command(fqs_pkg::CMD_FIND, 32'sd12345, '0);
        send_command(fqs_pkg::CMD_READ, '0, 4'd15);
        send_command(fqs_pkg::CMD_READ, '0, 4'd0);
        send_command(fqs_pkg::CMD_DROP, '0, '0);
        send_command(fqs_pkg::CMD_POP, '0, '0);
        send_command(fqs_pkg::CMD_SIZE, '0, '0);
        // drop down to a single entry, then empty
        send_command(fqs_pkg::CMD_DROP, '0, '0);
        send_command(fqs_pkg::CMD_DROP, '0, '0);
        send_command(fqs_pkg::CMD_SIZE, '0, '0);

        filling   = 1'b1;
        mode_left = $urandom_range(20, 50);
        for (phase = 0; phase < 3; phase++)
        begin
            sender_idle_pct = (phase == 0) ? 29 : (phase == 1) ? 81 : 0;
            for (n = 0; n < ITEMS_PER_PHASE; n++)
            begin
                if (mode_left == 0)
                begin
                    filling   = !filling;
                    mode_left = $urandom_range(20, 50);
                end
                mode_left--;
                send_command(pick_command(filling), pick_value(), IXW'($urandom_range(15)));
            end
        end

        start = 1'b0;
        while (sb.pending_replies.size() != 0)
            @(posedge clk);
        repeat (DEPTH + 4) @(posedge clk);
        if (sb.mismatches == 0 && sb.pending_replies.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

@@ files.f @@
design/fqs_pkg.sv
design/fqs_cell.sv
design/fqs_ctrl.sv
design/fifo_queue_with_search_unit.sv
bench/tb_fifo_queue_with_search_unit.sv
